### design/hmc_pkg.sv
// Package for the Horspool match counter: sizes, types and shared helpers.
`timescale 1ns / 1ps

package hmc_pkg;

    // Longest pattern the block holds and the size of the byte alphabet.
    localparam int MAX_PATTERN = 32;
    localparam int ALPHABET    = 256;

    // Widths, some derived from the sizes above.
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 6;
    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W   = $clog2(MAX_PATTERN);
    localparam int SYM_W   = $clog2(ALPHABET);
    localparam int TOTAL_W = 32;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [SYM_W-1:0]  t_sym;

    // Item kinds on the input channel.
    typedef enum logic {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } t_kind;

    // Write request from the pattern loader to the shift table.
    typedef struct packed {
        logic fill;
        t_len fill_value;
        logic wr;
        t_sym addr;
        t_len value;
    } t_shift_wr;

    // Status of the match stage, seen by the top level.
    typedef struct packed {
        logic s1_valid;
        logic s1_text;
    } t_match_stat;

    // Effective pattern length: zero counts as one, large values clamp.
    function automatic t_len eff_len(input logic [CFG_W-1:0] cfg);
        logic [CFG_W:0] wide;
        wide = {1'b0, cfg};
        if (wide == '0) begin
            return t_len'(1);
        end
        if (wide > (CFG_W+1)'(MAX_PATTERN)) begin
            return t_len'(MAX_PATTERN);
        end
        return t_len'(wide);
    endfunction

    // Table address of a byte.
    function automatic t_sym sym_of(input t_byte b);
        return b[SYM_W-1:0];
    endfunction

endpackage

### design/horspool_match_counter.sv
// Top level of the Horspool match counter: configuration register and block wiring.
`timescale 1ns / 1ps

// Counts occurrences of a byte pattern (1 to 32 bytes, set in pattern_length)
// in a streamed text. Load the pattern as items of kind 0, then stream text
// items of kind 1; the item marked last returns the saturating count. One item
// is taken every clock cycle while the input does not stall: the input item is
// registered while its shift entry is read from the 256-entry table memory,
// then the match stage does the window compare and count and loads the count
// into the output register. The input stalls only while a finished count waits
// on a stalled output. The shift table has a valid bit per entry, so a new
// pattern load takes effect at once with no clearing pass.

module horspool_match_counter
    import hmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  t_byte              i_data_byte,
    input  logic               i_last_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [TOTAL_W-1:0] o_match_count
);

    logic [CFG_W-1:0] r_pattern_length;
    t_len             len;
    logic             accept;
    t_shift_wr        shift_wr;
    logic             text_start;
    t_byte            pattern [MAX_PATTERN];
    t_len             shift;
    t_match_stat      stat;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pattern_length <= i_cfg_data;
        end
    end

    assign len    = eff_len(r_pattern_length);
    assign accept = i_in_valid && !o_in_stall;

    hmc_loader u_loader (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_last_item  (i_last_item),
        .i_len        (len),
        .o_shift_wr   (shift_wr),
        .o_text_start (text_start),
        .o_pattern    (pattern)
    );

    hmc_shift_table u_shift_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (shift_wr),
        .i_rd_en   (accept && (i_kind == KIND_TEXT)),
        .i_rd_addr (sym_of(i_data_byte)),
        .o_shift   (shift)
    );

    hmc_matcher u_matcher (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .i_last_item   (i_last_item),
        .i_text_start  (text_start),
        .i_len         (len),
        .i_shift       (shift),
        .i_pattern     (pattern),
        .i_out_stall   (i_out_stall),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_match_count (o_match_count),
        .o_stat        (stat)
    );

    // The input only stalls behind a waiting, stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A shift used by a text byte is always between one and the pattern maximum.
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.s1_valid && stat.s1_text) |-> ((shift != '0) && (shift <= t_len'(MAX_PATTERN))))
        else $error("shift table returned an out-of-range shift");

    // A new result comes only from a text item held in the match stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(stat.s1_valid && stat.s1_text))
        else $error("result appeared without a text item");

endmodule

### design/hmc_shift_table.sv
// Bad-character shift table: memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module hmc_shift_table
    import hmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_shift_wr i_wr,
    input  logic      i_rd_en,
    input  t_sym      i_rd_addr,
    output t_len      o_shift
);

    t_len               r_mem [ALPHABET];
    logic [ALPHABET-1:0] r_valid;
    logic [ALPHABET-1:0] n_valid;
    t_len               r_fill;
    t_len               r_rd_data;
    logic               r_rd_valid;
    t_len               r_rd_fill;

    // Table storage and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.wr) begin
            r_mem[i_wr.addr] <= i_wr.value;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // A fill invalidates every entry at once; a write in the same cycle lands after it.
    always_comb begin
        n_valid = r_valid;
        if (i_wr.fill) begin
            n_valid = '0;
        end
        if (i_wr.wr) begin
            n_valid[i_wr.addr] = 1'b1;
        end
    end

    // Valid bits, fill value and the read-side copies of both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fill     <= t_len'(1);
            r_rd_valid <= 1'b0;
            r_rd_fill  <= t_len'(1);
        end else begin
            r_valid <= n_valid;
            if (i_wr.fill) begin
                r_fill <= i_wr.fill_value;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_rd_fill  <= r_fill;
            end
        end
    end

    // An entry not written since the last fill reads as the fill value.
    assign o_shift = r_rd_valid ? r_rd_data : r_rd_fill;

endmodule

### design/hmc_loader.sv
// Pattern loader: tracks text and pattern phases, stores pattern bytes, drives table writes.
`timescale 1ns / 1ps

module hmc_loader
    import hmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic      i_kind,
    input  t_byte     i_data_byte,
    input  logic      i_last_item,
    input  t_len      i_len,
    output t_shift_wr o_shift_wr,
    output logic      o_text_start,
    output t_byte     o_pattern [MAX_PATTERN]
);

    t_len  r_widx;
    t_len  n_widx;
    logic  r_text_active;
    logic  n_text_active;
    t_byte r_pattern [MAX_PATTERN];
    logic  is_pattern;
    logic  store;

    assign is_pattern = i_accept && (i_kind == KIND_PATTERN);
    assign store      = is_pattern && (r_widx < i_len);

    // Table writes for a pattern byte: fill on the first one, then its own shift.
    always_comb begin
        o_shift_wr.fill       = is_pattern && (r_widx == '0);
        o_shift_wr.fill_value = i_len;
        o_shift_wr.wr         = is_pattern && (r_widx < (i_len - t_len'(1)));
        o_shift_wr.addr       = sym_of(i_data_byte);
        o_shift_wr.value      = i_len - t_len'(1) - r_widx;
    end

    // Phase tracking and write index.
    always_comb begin
        n_widx        = r_widx;
        n_text_active = r_text_active;
        o_text_start  = 1'b0;
        if (is_pattern) begin
            n_text_active = 1'b0;
            if (r_widx < t_len'(MAX_PATTERN)) begin
                n_widx = r_widx + t_len'(1);
            end
        end else if (i_accept) begin
            if (!r_text_active) begin
                o_text_start = 1'b1;
                n_widx       = '0;
            end
            n_text_active = !i_last_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx        <= '0;
            r_text_active <= 1'b0;
        end else begin
            r_widx        <= n_widx;
            r_text_active <= n_text_active;
        end
    end

    // Pattern bytes in use.
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_pattern[r_widx[IDX_W-1:0]] <= i_data_byte;
        end
    end

    assign o_pattern = r_pattern;

endmodule

### design/hmc_matcher.sv
// Match stage: text window, alignment countdown, parallel compare, count and output register.
`timescale 1ns / 1ps

module hmc_matcher
    import hmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_kind,
    input  t_byte              i_data_byte,
    input  logic               i_last_item,
    input  logic               i_text_start,
    input  t_len               i_len,
    input  t_len               i_shift,
    input  t_byte              i_pattern [MAX_PATTERN],
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output logic [TOTAL_W-1:0] o_match_count,
    output t_match_stat        o_stat
);

    // Stage register for the item whose shift entry is being read.
    logic               r_s1_valid;
    logic               r_s1_text;
    t_byte              r_s1_byte;
    logic               r_s1_last;
    logic               r_s1_start;

    t_byte              r_window [MAX_PATTERN];
    t_byte              n_window [MAX_PATTERN];
    t_len               r_countdown;
    t_len               n_countdown;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_count;

    logic                   s1_result;
    logic                   s1_go;
    logic                   out_free;
    logic                   s1_work;
    logic [MAX_PATTERN-1:0] lane_ok;
    logic                   window_hit;
    t_len                   cd_now;
    logic [TOTAL_W-1:0]     total_base;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_result  = r_s1_text && r_s1_last;
    assign s1_go      = !s1_result || out_free;
    assign s1_work    = r_s1_valid && s1_go;
    assign o_in_stall = r_s1_valid && !s1_go;

    // Window after this byte enters.
    always_comb begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            n_window[i] = r_window[i+1];
        end
        n_window[MAX_PATTERN-1] = r_s1_byte;
    end

    // Compare the newest m window bytes with the pattern, one lane per pattern byte.
    always_comb begin
        t_len sel;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            sel = t_len'(MAX_PATTERN) - i_len + t_len'(i);
            lane_ok[i] = (t_len'(i) >= i_len) ||
                         (i_pattern[i] == n_window[sel[IDX_W-1:0]]);
        end
        window_hit = &lane_ok;
    end

    // Countdown and occurrence count for a text byte.
    always_comb begin
        cd_now      = r_s1_start ? (i_len - t_len'(1)) : r_countdown;
        total_base  = r_s1_start ? '0 : r_total;
        n_countdown = cd_now - t_len'(1);
        n_total     = total_base;
        if (cd_now == '0) begin
            if (window_hit && (total_base != '1)) begin
                n_total = total_base + TOTAL_W'(1);
            end
            n_countdown = (i_shift == '0) ? '0 : (i_shift - t_len'(1));
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_text  <= (i_kind == KIND_TEXT);
            r_s1_byte  <= i_data_byte;
            r_s1_last  <= i_last_item;
            r_s1_start <= i_text_start;
        end
    end

    // Search state, advanced by each text byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
            r_total     <= '0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_window[i] <= '0;
            end
        end else if (s1_work && r_s1_text) begin
            r_countdown <= n_countdown;
            r_total     <= n_total;
            r_window    <= n_window;
        end
    end

    // Result register: loaded by the final text byte, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_work && s1_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_work && s1_result) begin
            r_out_count <= n_total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_count  = r_out_count;
    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.s1_text  = r_s1_text;

endmodule

### tb/hmc_search_checker.sv
// Checker for the Horspool match counter: tracks the search state and compares each count.
`timescale 1ns / 1ps

module hmc_search_checker
    import hmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_kind,
    input  t_byte              i_data_byte,
    input  logic               i_last_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [TOTAL_W-1:0] i_match_count,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_counts_checked,
    output int                 o_nonzero_counts
);

    // Local copy of everything the block keeps between items.
    logic [CFG_W-1:0]   length_reg;
    t_byte              pattern_mem [MAX_PATTERN];
    logic [CFG_W-1:0]   skip_mem [ALPHABET];
    t_byte              window_mem [MAX_PATTERN];
    int unsigned        load_pos;
    int unsigned        bytes_to_check;
    bit                 in_text;
    logic [TOTAL_W-1:0] running_total;
    logic [TOTAL_W-1:0] expected_counts [$];

    // Pattern length in use: zero means one, anything past the store clamps.
    function automatic int unsigned active_length();
        if (length_reg == '0) begin
            return 1;
        end
        if (length_reg > MAX_PATTERN) begin
            return MAX_PATTERN;
        end
        return length_reg;
    endfunction

    // Advances the search by one item and queues the count that a final text byte returns.
    task automatic advance_search(input t_kind kind, input t_byte b, input logic last);
        int unsigned m;
        int unsigned skip;
        int          k;
        bit          hit;
        m = active_length();

        // A pattern byte ends any text in progress and goes into the store.
        if (kind == KIND_PATTERN) begin
            in_text = 1'b0;
            if (load_pos == 0) begin
                foreach (skip_mem[j]) skip_mem[j] = CFG_W'(m);
            end
            if (load_pos < m) begin
                pattern_mem[load_pos] = b;
                if (load_pos + 1 < m) begin
                    skip_mem[b] = CFG_W'(m - 1 - load_pos);
                end
            end
            if (load_pos < MAX_PATTERN) begin
                load_pos++;
            end
            return;
        end

        // The first text byte clears the count and restarts pattern loading.
        if (!in_text) begin
            in_text        = 1'b1;
            running_total  = '0;
            load_pos       = 0;
            bytes_to_check = m - 1;
        end

        for (k = 0; k < MAX_PATTERN - 1; k++) begin
            window_mem[k] = window_mem[k+1];
        end
        window_mem[MAX_PATTERN-1] = b;

        // At an alignment end the newest m window bytes are compared with the pattern.
        if (bytes_to_check == 0) begin
            skip = skip_mem[b];
            hit  = 1'b1;
            for (k = 0; k < m; k++) begin
                if (pattern_mem[k] != window_mem[MAX_PATTERN - m + k]) begin
                    hit = 1'b0;
                end
            end
            if (hit && running_total != '1) begin
                running_total++;
            end
            if (skip == 0) begin
                skip = 1;
            end
            bytes_to_check = skip - 1;
        end else begin
            bytes_to_check--;
        end

        if (last) begin
            in_text = 1'b0;
            expected_counts.push_back(running_total);
        end
    endtask

    // Watch all three channels at each clock edge.
    always @(posedge i_clk) begin
        logic [TOTAL_W-1:0] want;
        if (!i_rst_n) begin
            length_reg     = CFG_W'(1);
            load_pos       = 0;
            bytes_to_check = 0;
            in_text        = 1'b0;
            running_total  = '0;
            foreach (skip_mem[j]) skip_mem[j] = CFG_W'(1);
            foreach (pattern_mem[j]) pattern_mem[j] = '0;
            foreach (window_mem[j]) window_mem[j] = '0;
            expected_counts.delete();
            o_fail_count     = 0;
            o_counts_checked = 0;
            o_nonzero_counts = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                length_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                advance_search(t_kind'(i_kind), i_data_byte, i_last_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    $error("match_count: expected no result, actual %0d", i_match_count);
                    o_fail_count++;
                end else begin
                    want = expected_counts.pop_front();
                    o_counts_checked++;
                    if (want != 0) begin
                        o_nonzero_counts++;
                    end
                    if (i_match_count !== want) begin
                        $error("match_count: expected %0d, actual %0d", want, i_match_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_counts.size();
    end

endmodule

### tb/tb_horspool_match_counter.sv
// Testbench top for the Horspool match counter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_horspool_match_counter;
    import hmc_pkg::*;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               in_kind   = 1'b0;
    t_byte              in_byte   = '0;
    logic               in_last   = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [TOTAL_W-1:0] match_count;

    int fail_count;
    int pending;
    int counts_checked;
    int nonzero_counts;

    // What the stimulus knows of the block's contents, so that no compare
    // ever reads a pattern entry that was never loaded.
    int unsigned cur_len     = 1;
    int unsigned held_pos    = 0;
    bit          held_text   = 1'b0;
    bit          held_written [MAX_PATTERN];
    t_byte       held_bytes [MAX_PATTERN];

    // Byte choice for the current sequence: two symbols, or the full range.
    bit    narrow = 1'b0;
    t_byte sym_a  = '0;
    t_byte sym_b  = '0;

    // When set, neither side idles.
    bit calm = 1'b0;

    int items_sent    = 0;
    int texts_done    = 0;
    int config_writes = 0;
    int stall_left    = 0;

    always #5 clk = ~clk;

    horspool_match_counter u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (in_kind),
        .i_data_byte   (in_byte),
        .i_last_item   (in_last),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_match_count (match_count)
    );

    hmc_search_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (in_kind),
        .i_data_byte      (in_byte),
        .i_last_item      (in_last),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_match_count    (match_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_counts_checked (counts_checked),
        .o_nonzero_counts (nonzero_counts)
    );

    // After each accepted result the receiver holds off for a random number of cycles.
    always @(posedge clk) begin
        int n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end else if (out_valid && !out_stall) begin
            n = calm ? 0 : $urandom_range(0, 7);
            stall_left <= n;
            out_stall  <= (n != 0);
        end
    end

    function automatic t_byte pick_byte();
        if (narrow) begin
            return ($urandom_range(0, 1) != 0) ? sym_a : sym_b;
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    // A text may start only once every pattern entry in use has been loaded.
    function automatic bit text_ready();
        int unsigned j;
        if (held_text) begin
            return 1'b1;
        end
        for (j = 0; j < cur_len; j++) begin
            if (!held_written[j]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Sends one item after a random gap and returns at the edge that accepts it.
    task automatic put_item(input t_kind kind, input t_byte b, input logic last);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_byte  <= b;
        in_last  <= last;
        do @(posedge clk); while (in_stall);

        if (kind == KIND_PATTERN) begin
            held_text = 1'b0;
            if (held_pos < cur_len) begin
                held_written[held_pos] = 1'b1;
                held_bytes[held_pos]   = b;
                items_sent++;
            end
            if (held_pos < MAX_PATTERN) begin
                held_pos++;
            end
        end else begin
            if (!held_text) begin
                held_text = 1'b1;
                held_pos  = 0;
            end
            items_sent++;
            if (last) begin
                held_text = 1'b0;
                texts_done++;
            end
        end
    endtask

    // Waits until every count is back and the pipeline has drained.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_len = (v == 0) ? 1 : ((v > MAX_PATTERN) ? MAX_PATTERN : v);
        config_writes++;
    endtask

    // Loads a whole pattern from entry zero, plus some ignored bytes.
    task automatic load_full_pattern(input int unsigned extra);
        int unsigned j;
        // A one-byte text puts the load index back to zero; it compares
        // nothing unless the length is one, and entry zero is then loaded.
        if (held_pos != 0) begin
            put_item(KIND_TEXT, pick_byte(), 1'b1);
        end
        for (j = 0; j < cur_len + extra; j++) begin
            put_item(KIND_PATTERN, pick_byte(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Streams a text with copies of the pattern spliced into random bytes.
    task automatic send_text(input bit with_last);
        int unsigned len;
        int unsigned pos;
        int unsigned j;
        if (!text_ready()) begin
            load_full_pattern(0);
        end
        if (cur_len > 16) begin
            len = $urandom_range(cur_len - 2, cur_len + 10);
        end else begin
            len = $urandom_range(1, 4 * cur_len + 8);
        end
        pos = 0;
        while (pos < len) begin
            if (pos + cur_len <= len && $urandom_range(0, 2) == 0) begin
                for (j = 0; j < cur_len; j++) begin
                    put_item(KIND_TEXT, held_bytes[j], with_last && pos + 1 == len);
                    pos++;
                end
            end else begin
                put_item(KIND_TEXT, pick_byte(), with_last && pos + 1 == len);
                pos++;
            end
        end
    endtask

    // Mostly a full load followed by a text; sometimes reuse, partial reload, abandon or noise.
    task automatic random_sequence();
        int unsigned pick;
        int unsigned k;
        pick   = $urandom_range(0, 9);
        narrow = ($urandom_range(0, 3) != 0);
        sym_a  = t_byte'($urandom_range(0, 255));
        sym_b  = t_byte'($urandom_range(0, 255));
        if (pick <= 5) begin
            load_full_pattern(($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
            send_text(1'b1);
        end else if (pick == 6) begin
            send_text(1'b1);
        end else if (pick == 7) begin
            // The text is cut off by a new pattern and gives no count.
            load_full_pattern(0);
            send_text(1'b0);
            load_full_pattern(0);
            send_text(1'b1);
        end else if (pick == 8) begin
            // Partial reload over an older pattern of at least this length.
            if (held_pos == 0 && cur_len > 1 && text_ready()) begin
                k = $urandom_range(1, cur_len - 1);
                repeat (k) put_item(KIND_PATTERN, pick_byte(), 1'b0);
            end
            send_text(1'b1);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                put_item(KIND_PATTERN, t_byte'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end
            send_text(1'b1);
        end
    endtask

    initial begin : stimulus
        int               phase;
        int               wait_cycles;
        logic [CFG_W-1:0] setting;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte pattern, a set last flag on it, repeat hits and a miss.
        write_length(6'd0);
        put_item(KIND_PATTERN, 8'hFF, 1'b1);
        put_item(KIND_TEXT, 8'hFF, 1'b0);
        put_item(KIND_TEXT, 8'h00, 1'b0);
        put_item(KIND_TEXT, 8'hFF, 1'b1);
        put_item(KIND_TEXT, 8'h00, 1'b1);
        settle();

        // Three bytes with an ignored extra, a short text, overlapping hits,
        // then a text cut off by a reload.
        write_length(6'd3);
        put_item(KIND_PATTERN, 8'h00, 1'b0);
        put_item(KIND_PATTERN, 8'hFF, 1'b0);
        put_item(KIND_PATTERN, 8'h00, 1'b1);
        put_item(KIND_PATTERN, 8'h5A, 1'b0);
        put_item(KIND_TEXT, 8'h01, 1'b0);
        put_item(KIND_TEXT, 8'h02, 1'b1);
        put_item(KIND_TEXT, 8'h00, 1'b0);
        put_item(KIND_TEXT, 8'hFF, 1'b0);
        put_item(KIND_TEXT, 8'h00, 1'b0);
        put_item(KIND_TEXT, 8'hFF, 1'b0);
        put_item(KIND_TEXT, 8'h00, 1'b1);
        put_item(KIND_TEXT, 8'h00, 1'b0);
        put_item(KIND_TEXT, 8'hFF, 1'b0);
        put_item(KIND_PATTERN, 8'h00, 1'b0);
        put_item(KIND_PATTERN, 8'hFF, 1'b0);
        put_item(KIND_PATTERN, 8'h00, 1'b0);
        put_item(KIND_TEXT, 8'h00, 1'b0);
        put_item(KIND_TEXT, 8'hFF, 1'b0);
        put_item(KIND_TEXT, 8'h00, 1'b1);

        // Random phases: the length extremes first, then mostly short patterns.
        phase = 0;
        while (items_sent < 500) begin
            settle();
            case (phase)
                0:       setting = 6'd63;
                1:       setting = 6'd32;
                2:       setting = 6'd33;
                3:       setting = 6'd1;
                4:       setting = 6'd0;
                5:       setting = 6'd2;
                default: begin
                    if ($urandom_range(0, 3) != 0) begin
                        setting = CFG_W'($urandom_range(1, 6));
                    end else begin
                        setting = CFG_W'($urandom_range(0, 63));
                    end
                end
            endcase
            write_length(setting);
            calm = ($urandom_range(0, 3) == 0);
            repeat ((cur_len > 16) ? 1 : $urandom_range(3, 6)) random_sequence();
            phase++;
        end

        // Drain, then allow time for any stray result.
        in_valid <= 1'b0;
        wait_cycles = 0;
        @(negedge clk);
        while (pending != 0 && wait_cycles < 1000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (pending != 0) begin
            $error("match_count: %0d expected results never arrived", pending);
        end

        $display("Sent %0d items in %0d texts over %0d pattern length writes.",
                 items_sent, texts_done, config_writes);
        $display("Checked %0d counts, %0d of them nonzero.", counts_checked, nonzero_counts);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_horspool_match_counter OK");
        end else begin
            $display("tb_horspool_match_counter NOT OK");
        end
        $finish;
    end

    // Hard stop if the handshakes hang.
    initial begin : watchdog
        #2_000_000;
        $display("tb_horspool_match_counter NOT OK");
        $finish;
    end

endmodule

### horspool_match_counter.f
design/hmc_pkg.sv
design/hmc_shift_table.sv
design/hmc_loader.sv
design/hmc_matcher.sv
design/horspool_match_counter.sv
tb/hmc_search_checker.sv
tb/tb_horspool_match_counter.sv
